/* rtl/core/bdbs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdbs_pkg: shared types and constants of the batched drain backoff scheduler
// Beat layouts, opcodes, action codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package bdbs_pkg;

    localparam int ACTIVITY_BITS_DEF = 16;
    localparam int OUT_ACT_W         = 16;
    localparam int TIME_W            = 32;
    localparam int CFG_ADDR_W        = 3;
    localparam int CFG_DATA_W        = 32;

    // Input opcodes
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_OFFER = 2'd2;

    // Result actions
    localparam logic [1:0] ACT_NONE    = 2'd0;
    localparam logic [1:0] ACT_OPEN    = 2'd1;
    localparam logic [1:0] ACT_DRAIN   = 2'd2;
    localparam logic [1:0] ACT_COUNTED = 2'd3;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_DRAIN_THRESHOLD = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_INTERVAL    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE_TIME     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BACKOFF_BASE    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BACKOFF_CAP     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_RETRY      = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SYNC_ENABLED    = 3'd6;

    // Reset values
    localparam logic [15:0]       DRAIN_THRESHOLD_RST = 16'd4;
    localparam logic [TIME_W-1:0] MAX_INTERVAL_RST    = 32'd600000;
    localparam logic [TIME_W-1:0] SETTLE_TIME_RST     = 32'd200;
    localparam logic [TIME_W-1:0] BACKOFF_BASE_RST    = 32'd30000;
    localparam logic [TIME_W-1:0] BACKOFF_CAP_RST     = 32'd3600000;
    localparam logic [TIME_W-1:0] SYNC_RETRY_RST      = 32'd300000;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [TIME_W-1:0] now_ms;
        logic [15:0]       initial_pending;
        logic              offer_counted;
        logic              sync_due;
        logic              station_up;
        logic              drain_clean;
    } in_beat_t;

    typedef struct packed {
        logic [1:0]           action;
        logic                 cycle_succeeded;
        logic [OUT_ACT_W-1:0] activity_count;
        logic [TIME_W-1:0]    next_allowed_time;
        logic [TIME_W-1:0]    current_backoff;
        logic [TIME_W-1:0]    cycles_done;
    } out_beat_t;

    typedef struct packed {
        logic [15:0]       drain_threshold;
        logic [TIME_W-1:0] max_drain_interval;
        logic [TIME_W-1:0] settle_time;
        logic [TIME_W-1:0] backoff_base;
        logic [TIME_W-1:0] backoff_cap;
        logic [TIME_W-1:0] sync_retry_interval;
        logic              sync_enabled;
        logic              interval_wr;
    } cfg_t;

    // Wrap-safe deadline test: reached when (now - deadline) is non-negative
    function automatic logic reached(input logic [TIME_W-1:0] now,
                                     input logic [TIME_W-1:0] deadline);
        logic [TIME_W-1:0] diff;
        diff = now - deadline;
        return ~diff[TIME_W-1];
    endfunction

endpackage

/* rtl/core/batched_drain_backoff_scheduler_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// batched_drain_backoff_scheduler_top: drain window scheduler
// Coalesces capture activity into drain windows, with a settle phase and a
// capped exponential backoff after failed drain cycles.
// ----------------------------------------------------------------------------
//  channel   | ports                          | beat
//  ----------+--------------------------------+------------------------------
//  input     | s_valid, s_ready, s_data       | start / tick / capture event
//  result    | m_valid, m_ready, m_data       | action and scheduler status
//  config    | cfg_we, cfg_addr, cfg_wdata    | register write, no wait
//
//  Each beat sits in the input register, and one pass of deadline compares and
//  32-bit adds updates the state and fills the result register, which drives
//  m_valid and m_data; a beat passes the input and then the result register.
//  A beat is taken every cycle while the result side keeps up; a stalled
//  result holds in its register while one more beat waits in the input stage.
//  Reset (aresetn low, synchronous) empties both stages and restores the
//  state and registers to their defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module batched_drain_backoff_scheduler_top
    import bdbs_pkg::*;
#(
    parameter int ACTIVITY_BITS = ACTIVITY_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Compare width covers both the activity counter and the 16-bit fields
    localparam int CMP_W = (ACTIVITY_BITS > OUT_ACT_W) ? ACTIVITY_BITS : OUT_ACT_W;
    localparam logic [ACTIVITY_BITS-1:0] ACT_MAX = '1;
    localparam logic [OUT_ACT_W-1:0]     OUT_MAX = '1;

    cfg_t cfg;

    bdbs_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Pipeline stages
    logic      in_valid_reg, in_valid_next;
    in_beat_t  in_reg;
    logic      out_valid_reg;
    out_beat_t out_reg, out_next;
    logic      advance;
    logic      s_accept;
    logic      fire;

    // Scheduler state
    logic                     settling_reg, settling_next;
    logic [ACTIVITY_BITS-1:0] activity_reg, activity_next;
    logic [TIME_W-1:0]        last_drain_reg, last_drain_next;
    logic [TIME_W-1:0]        ceiling_reg, ceiling_next;
    logic [TIME_W-1:0]        allowed_reg, allowed_next;
    logic [TIME_W-1:0]        sync_win_reg, sync_win_next;
    logic [TIME_W-1:0]        settle_end_reg, settle_end_next;
    logic [TIME_W-1:0]        backoff_reg, backoff_next;
    logic [TIME_W-1:0]        cycles_reg, cycles_next;

    // Decision terms
    logic [CMP_W-1:0] act_w;
    logic [CMP_W-1:0] pend_w;
    logic             window_due;
    logic             cycle_ok;
    logic [1:0]       action;

    // Result side frees the input stage when empty or taken this cycle
    assign advance  = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;
    assign fire     = in_valid_reg && advance;

    assign act_w  = CMP_W'(activity_reg);
    assign pend_w = CMP_W'(in_reg.initial_pending);

    // Window opens past the backoff deadline on threshold, ceiling or sync gate
    always_comb begin
        window_due = 1'b0;
        if (reached(in_reg.now_ms, allowed_reg)) begin
            if (act_w >= CMP_W'(cfg.drain_threshold)) begin
                window_due = 1'b1;
            end else if ((activity_reg != '0) && reached(in_reg.now_ms, ceiling_reg)) begin
                window_due = 1'b1;
            end else if (cfg.sync_enabled && in_reg.sync_due
                         && reached(in_reg.now_ms, sync_win_reg)) begin
                window_due = 1'b1;
            end
        end
    end

    always_comb begin
        settling_next   = settling_reg;
        activity_next   = activity_reg;
        last_drain_next = last_drain_reg;
        ceiling_next    = ceiling_reg;
        allowed_next    = allowed_reg;
        sync_win_next   = sync_win_reg;
        settle_end_next = settle_end_reg;
        backoff_next    = backoff_reg;
        cycles_next     = cycles_reg;
        action          = ACT_NONE;
        cycle_ok        = 1'b0;

        case (in_reg.opcode)
            OP_START: begin
                last_drain_next = in_reg.now_ms;
                ceiling_next    = in_reg.now_ms + cfg.max_drain_interval;
                allowed_next    = in_reg.now_ms;
                sync_win_next   = in_reg.now_ms;
                backoff_next    = cfg.backoff_base;
                settling_next   = 1'b0;
                if (pend_w > CMP_W'(ACT_MAX)) begin
                    activity_next = ACT_MAX;
                end else begin
                    activity_next = pend_w[ACTIVITY_BITS-1:0];
                end
            end
            OP_OFFER: begin
                if (in_reg.offer_counted) begin
                    if (activity_reg != ACT_MAX) begin
                        activity_next = activity_reg + ACTIVITY_BITS'(1);
                    end
                    action = ACT_COUNTED;
                end
            end
            OP_TICK: begin
                if (!settling_reg) begin
                    if (window_due) begin
                        settling_next   = 1'b1;
                        settle_end_next = in_reg.now_ms + cfg.settle_time;
                        action          = ACT_OPEN;
                    end
                end else if (reached(in_reg.now_ms, settle_end_reg)) begin
                    cycle_ok = in_reg.station_up && in_reg.drain_clean;
                    if (in_reg.station_up && cfg.sync_enabled && in_reg.sync_due) begin
                        sync_win_next = in_reg.now_ms + cfg.sync_retry_interval;
                    end
                    last_drain_next = in_reg.now_ms;
                    ceiling_next    = in_reg.now_ms + cfg.max_drain_interval;
                    if (cycle_ok) begin
                        backoff_next  = cfg.backoff_base;
                        allowed_next  = in_reg.now_ms;
                        activity_next = '0;
                    end else begin
                        allowed_next = in_reg.now_ms + backoff_reg;
                        // Double the backoff until it reaches the cap
                        if (backoff_reg >= (cfg.backoff_cap >> 1)) begin
                            backoff_next = cfg.backoff_cap;
                        end else begin
                            backoff_next = backoff_reg << 1;
                        end
                    end
                    cycles_next   = cycles_reg + TIME_W'(1);
                    settling_next = 1'b0;
                    action        = ACT_DRAIN;
                end
            end
            default: begin
            end
        endcase
    end

    // Assemble the result beat from the post-item state
    always_comb begin
        out_next.action          = action;
        out_next.cycle_succeeded = cycle_ok;
        if (CMP_W'(activity_next) > CMP_W'(OUT_MAX)) begin
            out_next.activity_count = OUT_MAX;
        end else begin
            out_next.activity_count = OUT_ACT_W'(activity_next);
        end
        out_next.next_allowed_time = allowed_next;
        out_next.current_backoff   = backoff_next;
        out_next.cycles_done       = cycles_next;
    end

    // Input stage: load on accept, drop when the beat moves on
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
        if (s_accept) begin
            in_reg <= s_data;
        end
    end

    // Result stage: hold while stalled, advance otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
        if (fire) begin
            out_reg <= out_next;
        end
    end

    // State commits only when a beat is processed; interval writes rebuild the ceiling
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settling_reg   <= 1'b0;
            activity_reg   <= '0;
            last_drain_reg <= '0;
            ceiling_reg    <= MAX_INTERVAL_RST;
            allowed_reg    <= '0;
            sync_win_reg   <= '0;
            settle_end_reg <= '0;
            backoff_reg    <= BACKOFF_BASE_RST;
            cycles_reg     <= '0;
        end else begin
            if (fire) begin
                settling_reg   <= settling_next;
                activity_reg   <= activity_next;
                last_drain_reg <= last_drain_next;
                allowed_reg    <= allowed_next;
                sync_win_reg   <= sync_win_next;
                settle_end_reg <= settle_end_next;
                backoff_reg    <= backoff_next;
                cycles_reg     <= cycles_next;
            end
            if (cfg.interval_wr) begin
                ceiling_reg <= last_drain_reg + cfg_wdata;
            end else if (fire) begin
                ceiling_reg <= ceiling_next;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    a_open_enters_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && action == ACT_OPEN) |=> settling_reg)
        else $error("window opened without entering settle");

    a_drain_leaves_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && action == ACT_DRAIN) |=>
            (!settling_reg && cycles_reg == $past(cycles_reg) + TIME_W'(1)))
        else $error("drain cycle did not return to hunting or count");

    a_ok_only_on_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (!m_data.cycle_succeeded || m_data.action == ACT_DRAIN))
        else $error("success flag outside a drain cycle");

    a_stall_means_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");
`endif

endmodule

/* rtl/core/bdbs_cfg_regs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdbs_cfg_regs: configuration register file
// Decodes register writes and holds the scheduler settings.
// ----------------------------------------------------------------------------
module bdbs_cfg_regs
    import bdbs_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    logic [15:0]       threshold_reg;
    logic [TIME_W-1:0] interval_reg;
    logic [TIME_W-1:0] settle_reg;
    logic [TIME_W-1:0] base_reg;
    logic [TIME_W-1:0] cap_reg;
    logic [TIME_W-1:0] retry_reg;
    logic              sync_en_reg;
    logic              interval_wr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= DRAIN_THRESHOLD_RST;
            interval_reg  <= MAX_INTERVAL_RST;
            settle_reg    <= SETTLE_TIME_RST;
            base_reg      <= BACKOFF_BASE_RST;
            cap_reg       <= BACKOFF_CAP_RST;
            retry_reg     <= SYNC_RETRY_RST;
            sync_en_reg   <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DRAIN_THRESHOLD: threshold_reg <= cfg_wdata[15:0];
                REG_MAX_INTERVAL:    interval_reg  <= cfg_wdata;
                REG_SETTLE_TIME:     settle_reg    <= cfg_wdata;
                REG_BACKOFF_BASE:    base_reg      <= cfg_wdata;
                REG_BACKOFF_CAP:     cap_reg       <= cfg_wdata;
                REG_SYNC_RETRY:      retry_reg     <= cfg_wdata;
                REG_SYNC_ENABLED:    sync_en_reg   <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // Flag the interval write so the drain ceiling can be rebuilt
    assign interval_wr = cfg_we && (cfg_addr == REG_MAX_INTERVAL);

    assign cfg.drain_threshold     = threshold_reg;
    assign cfg.max_drain_interval  = interval_reg;
    assign cfg.settle_time         = settle_reg;
    assign cfg.backoff_base        = base_reg;
    assign cfg.backoff_cap         = cap_reg;
    assign cfg.sync_retry_interval = retry_reg;
    assign cfg.sync_enabled        = sync_en_reg;
    assign cfg.interval_wr         = interval_wr;

endmodule
